/* hw/rtl/lbvs_pkg.sv */
`default_nettype none
package lbvs_pkg;

  localparam int unsigned DefMaxJoints = 32;
  localparam int unsigned DefFracBits  = 16;
  localparam int unsigned WeightBits   = 16;
  localparam int unsigned AccBits      = 48;
  localparam int unsigned FifoDepth    = 4;

  typedef enum logic [1:0] {
    OpWrCur  = 2'd0,
    OpWrBind = 2'd1,
    OpVertex = 2'd2,
    OpNop    = 2'd3
  } op_e;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [4:0]         joint_number;
    logic [1:0]         matrix_row;
    logic [1:0]         matrix_col;
    logic signed [31:0] entry_value;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [16:0]        weight;
    logic               last_of_vertex;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
  } out_word_t;

  // Command handed from the front end to the back end.
  typedef struct packed {
    logic               known;
    logic [4:0]         joint_number;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [16:0]        weight;
    logic               last_of_vertex;
  } cmd_t;

  // Round half up by s bits, then arithmetic shift.
  function automatic logic signed [80:0] rnd_shift(input logic signed [80:0] v,
                                                   input int unsigned s);
    logic signed [80:0] b;
    b = v + (81'sd1 <<< (s - 1));
    return b >>> s;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [80:0] v);
    if (v > 81'sd2147483647) return 32'sh7fffffff;
    if (v < -81'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [80:0] v);
    if (v > 81'sd140737488355327) return 48'sh7fffffffffff;
    if (v < -81'sd140737488355328) return 48'sh800000000000;
    return v[47:0];
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/lbvs_ram.sv */
`default_nettype none
module lbvs_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 512
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

/* hw/rtl/lbvs_front.sv */
`default_nettype none
module lbvs_front
  import lbvs_pkg::*;
#(
  parameter int unsigned MaxJoints = DefMaxJoints,
  localparam int unsigned AddrBits = $clog2(MaxJoints * 16)
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  output      logic          full_o,
  input  wire in_word_t      in_i,
  input  wire logic          busy_i,
  output      logic          cur_we_o,
  output      logic          bind_we_o,
  output      logic [AddrBits-1:0] waddr_o,
  output      logic [31:0]   wdata_o,
  output      logic          cmd_valid_o,
  output      cmd_t          cmd_o,
  input  wire logic          cmd_pop_i
);
  localparam int unsigned PtrBits = $clog2(FifoDepth);

  cmd_t               fifo_q [FifoDepth];
  logic [PtrBits-1:0] wptr_q, rptr_q;
  logic [PtrBits:0]   cnt_q;
  logic               acc, is_vertex, is_write, known, put, q_full;

  assign q_full    = (cnt_q == (PtrBits+1)'(FifoDepth));
  assign is_write  = (in_i.opcode == OpWrCur) || (in_i.opcode == OpWrBind);
  // A matrix write waits until every queued contribution has read its matrices.
  assign full_o    = q_full || (is_write && ((cnt_q != '0) || busy_i));
  assign acc       = push_i && !full_o;
  assign known     = 32'(in_i.joint_number) < MaxJoints;
  assign is_vertex = (in_i.opcode == OpVertex);
  assign put       = acc && is_vertex;

  assign cur_we_o  = acc && known && (in_i.opcode == OpWrCur);
  assign bind_we_o = acc && known && (in_i.opcode == OpWrBind);
  assign waddr_o   = AddrBits'({in_i.joint_number, in_i.matrix_row, in_i.matrix_col});
  assign wdata_o   = in_i.entry_value;

  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = fifo_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (put) begin
      fifo_q[wptr_q] <= '{known: known, joint_number: in_i.joint_number,
                          pos_x: in_i.pos_x, pos_y: in_i.pos_y, pos_z: in_i.pos_z,
                          weight: in_i.weight, last_of_vertex: in_i.last_of_vertex};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (put) wptr_q <= wptr_q + 1'b1;
      if (cmd_pop_i) rptr_q <= rptr_q + 1'b1;
      cnt_q <= cnt_q + (PtrBits+1)'(put) - (PtrBits+1)'(cmd_pop_i);
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/lbvs_back.sv */
`default_nettype none
module lbvs_back
  import lbvs_pkg::*;
#(
  parameter int unsigned MaxJoints = DefMaxJoints,
  parameter int unsigned FracBits  = DefFracBits,
  localparam int unsigned AddrBits = $clog2(MaxJoints * 16)
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cmd_valid_i,
  input  wire cmd_t          cmd_i,
  output      logic          cmd_pop_o,
  output      logic          busy_o,
  output      logic [AddrBits-1:0] cur_raddr_o,
  output      logic [AddrBits-1:0] bind_raddr_o,
  input  wire logic [31:0]   cur_rdata_i,
  input  wire logic [31:0]   bind_rdata_i,
  output      logic          empty_o,
  input  wire logic          pop_i,
  output      out_word_t     out_o
);
  // Sequencer: for each row r, for each column c, four k steps through the
  // matrix product multiplier; then weight step. Matrix memory reads are registered.
  localparam logic [2:0] SIdle = 3'd0, SMat = 3'd1, SPos = 3'd2, SWgt = 3'd3,
                         SAcc = 3'd4, SOut = 3'd5;

  logic [2:0]  st_q;
  logic [1:0]  r_q, c_q, k_q;
  logic        rd_q;      // read data valid for step in flight
  logic [1:0]  rk_q;
  logic signed [80:0] m_q, p_q;
  logic signed [47:0] acc_q [3];
  logic signed [33:0] term_q;
  logic        ovalid_q;
  out_word_t   out_q;
  logic signed [63:0] prod, mprod;
  logic signed [49:0] wprod;
  logic signed [80:0] mx, pc, wterm;
  logic signed [31:0] msat, pos_c, psat;
  logic        issue, done_k;

  assign cur_raddr_o  = AddrBits'({cmd_i.joint_number, r_q, k_q} & {5'h1f, 4'hf});
  assign bind_raddr_o = AddrBits'({cmd_i.joint_number, k_q, c_q});
  assign issue  = (st_q == SMat);
  assign prod   = $signed(cur_rdata_i) * $signed(bind_rdata_i);
  assign mx     = m_q + rnd_shift(81'(prod), FracBits);
  assign msat   = sat32(m_q);
  assign done_k = rd_q && (rk_q == 2'd3);

  always_comb begin
    unique case (c_q)
      2'd0:    pos_c = cmd_i.pos_x;
      2'd1:    pos_c = cmd_i.pos_y;
      default: pos_c = cmd_i.pos_z;
    endcase
  end
  assign mprod = msat * pos_c;
  assign pc = (c_q == 2'd3) ? 81'(msat) : rnd_shift(81'(mprod), FracBits);

  assign psat  = sat32(p_q);
  assign wprod = psat * $signed({1'b0, cmd_i.weight});
  assign wterm = rnd_shift(81'(wprod), WeightBits);

  assign empty_o = !ovalid_q;
  assign out_o   = out_q;
  assign cmd_pop_o = (st_q == SOut) && !ovalid_q;
  assign busy_o    = (st_q != SIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle; r_q <= '0; c_q <= '0; k_q <= '0; rd_q <= 1'b0; rk_q <= '0;
      m_q <= '0; p_q <= '0; ovalid_q <= 1'b0; term_q <= '0; out_q <= '0;
      for (int i = 0; i < 3; i++) begin
        acc_q[i] <= '0;
      end
    end else begin
      if (ovalid_q && pop_i) ovalid_q <= 1'b0;
      rd_q <= issue && !(done_k);
      rk_q <= k_q;
      unique case (st_q)
        SIdle: begin
          r_q <= '0; c_q <= '0; k_q <= '0; m_q <= '0; p_q <= '0;
          if (cmd_valid_i) st_q <= cmd_i.known ? SMat : SOut;
        end
        SMat: begin
          if (rd_q) m_q <= mx;
          if (!done_k && k_q != 2'd3) k_q <= k_q + 1'b1;
          if (done_k) st_q <= SPos;
        end
        SPos: begin
          p_q <= p_q + pc;
          m_q <= '0;
          k_q <= '0;
          if (c_q == 2'd3) begin
            st_q <= SWgt;
          end else begin
            c_q <= c_q + 1'b1;
            st_q <= SMat;
          end
        end
        SWgt: begin
          term_q <= wterm[33:0];
          st_q <= SAcc;
        end
        SAcc: begin
          acc_q[r_q] <= sat48(81'(acc_q[r_q]) + 81'(term_q));
          p_q <= '0; c_q <= '0;
          if (r_q == 2'd2) st_q <= SOut;
          else begin
            r_q <= r_q + 1'b1;
            st_q <= SMat;
          end
        end
        SOut: begin
          if (!ovalid_q) begin
            if (cmd_i.last_of_vertex) begin
              ovalid_q <= 1'b1;
              out_q <= '{out_x: sat32(81'(acc_q[0])), out_y: sat32(81'(acc_q[1])),
                         out_z: sat32(81'(acc_q[2]))};
              for (int i = 0; i < 3; i++) acc_q[i] <= '0;
            end
            st_q <= SIdle;
          end
        end
        default: st_q <= SIdle;
      endcase
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/linear_blend_vertex_skinning_top.sv */
`default_nettype none
// Linear blend vertex skinning engine, Q16.16, weights in unsigned Q1.16. Words
// are matrix-entry writes or vertex contributions. The back end works through
// one contribution in steps: a start step, then for each of the 3 rows 4
// columns of the four matrix products (the matrix memory read is registered)
// plus one transform step, then one weighting and one accumulate step per row,
// and a last step to hand the word on. Three multipliers serve the matrix
// product, the transform and the weighting. A four-deep queue between the front
// and back ends takes contributions while one is computed. A matrix write is
// held off with full high until the queue is empty and the back end is idle, so
// it takes effect in order. A contribution with last_of_vertex set yields one
// result word and clears the accumulators; while that word is not popped, the
// back end waits at the end of its next contribution.
module linear_blend_vertex_skinning_top
  import lbvs_pkg::*;
#(
  parameter int unsigned MaxJoints = DefMaxJoints,
  parameter int unsigned FracBits  = DefFracBits
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push,
  output      logic      full,
  input  wire in_word_t  in_i,
  output      logic      empty,
  input  wire logic      pop,
  output      out_word_t out_o
);
  localparam int unsigned AddrBits = $clog2(MaxJoints * 16);

  logic cur_we, bind_we, cmd_valid, cmd_pop, back_busy;
  logic [AddrBits-1:0] waddr, cur_ra, bind_ra;
  logic [31:0] wdata, cur_rd, bind_rd;
  cmd_t cmd;

  lbvs_front #(.MaxJoints(MaxJoints)) u_front (
    .clk_i, .rst_ni, .push_i(push), .full_o(full), .in_i, .busy_i(back_busy),
    .cur_we_o(cur_we), .bind_we_o(bind_we), .waddr_o(waddr), .wdata_o(wdata),
    .cmd_valid_o(cmd_valid), .cmd_o(cmd), .cmd_pop_i(cmd_pop)
  );

  lbvs_ram #(.Width(32), .Depth(MaxJoints * 16)) u_cur (
    .clk_i, .we_i(cur_we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(cur_ra), .rdata_o(cur_rd)
  );

  lbvs_ram #(.Width(32), .Depth(MaxJoints * 16)) u_bind (
    .clk_i, .we_i(bind_we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(bind_ra), .rdata_o(bind_rd)
  );

  lbvs_back #(.MaxJoints(MaxJoints), .FracBits(FracBits)) u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_i(cmd), .cmd_pop_o(cmd_pop),
    .busy_o(back_busy), .cur_raddr_o(cur_ra), .bind_raddr_o(bind_ra),
    .cur_rdata_i(cur_rd), .bind_rdata_i(bind_rd),
    .empty_o(empty), .pop_i(pop), .out_o
  );
endmodule
`default_nettype wire

/* tb/sv/lbvs_checker.sv */
module lbvs_checker
  import lbvs_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  wire logic      full_i,
  input  wire in_word_t  in_i,
  input  wire logic      empty_i,
  input  wire logic      pop_i,
  input  wire out_word_t out_i,
  output int             fail_count_o,
  output int             pending_o
);

  localparam int unsigned Joints = DefMaxJoints;

  logic signed [31:0] cur_mat[Joints*16];
  logic signed [31:0] bind_mat[Joints*16];
  logic signed [47:0] sum_x, sum_y, sum_z;
  out_word_t skinned_q[$];

  initial begin
    fail_count_o = 0;
    pending_o = 0;
  end

  function automatic logic signed [80:0] round_half_up(logic signed [80:0] v, int s);
    logic signed [80:0] b;
    b = v + (81'sd1 <<< (s - 1));
    return b >>> s;
  endfunction

  function automatic logic signed [80:0] clip(logic signed [80:0] v, int bits);
    logic signed [80:0] hi, lo;
    hi = (81'sd1 <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    fail_count_o++;
  endtask

  task automatic skin_word(in_word_t w);
    int base;
    logic signed [80:0] m, p, acc, pos[3], term[3];
    out_word_t r;
    base = int'(w.joint_number) * 16;
    if (w.opcode == OpWrCur) begin
      cur_mat[base + w.matrix_row*4 + w.matrix_col] = w.entry_value;
    end else if (w.opcode == OpWrBind) begin
      bind_mat[base + w.matrix_row*4 + w.matrix_col] = w.entry_value;
    end else if (w.opcode == OpVertex) begin
      pos[0] = w.pos_x; pos[1] = w.pos_y; pos[2] = w.pos_z;
      for (int rr = 0; rr < 3; rr++) begin
        p = 0;
        for (int c = 0; c < 4; c++) begin
          m = 0;
          for (int k = 0; k < 4; k++)
            m += round_half_up(81'(cur_mat[base + rr*4 + k]) *
                               81'(bind_mat[base + k*4 + c]), DefFracBits);
          m = clip(m, 32);
          if (c < 3) p += round_half_up(m * pos[c], DefFracBits);
          else p += m;
        end
        p = clip(p, 32);
        term[rr] = round_half_up(p * $signed({64'd0, w.weight}), WeightBits);
      end
      acc = sum_x; sum_x = 48'(clip(acc + term[0], 48));
      acc = sum_y; sum_y = 48'(clip(acc + term[1], 48));
      acc = sum_z; sum_z = 48'(clip(acc + term[2], 48));
      if (w.last_of_vertex) begin
        r.out_x = 32'(clip(81'(sum_x), 32));
        r.out_y = 32'(clip(81'(sum_y), 32));
        r.out_z = 32'(clip(81'(sum_z), 32));
        skinned_q = {skinned_q, r};
        sum_x = 0; sum_y = 0; sum_z = 0;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t want;
    if (!rst_ni) begin
      sum_x = 0; sum_y = 0; sum_z = 0;
      skinned_q.delete();
      pending_o = 0;
    end else begin
      if (pop_i && !empty_i) begin
        if (skinned_q.size() == 0) begin
          report_mismatch("unexpected word", out_i.out_x, 32'h0);
        end else begin
          want = skinned_q.pop_front();
          if (out_i.out_x !== want.out_x) report_mismatch("out_x", out_i.out_x, want.out_x);
          if (out_i.out_y !== want.out_y) report_mismatch("out_y", out_i.out_y, want.out_y);
          if (out_i.out_z !== want.out_z) report_mismatch("out_z", out_i.out_z, want.out_z);
        end
      end
      if (push_i && !full_i) skin_word(in_i);
      pending_o = skinned_q.size();
    end
  end

endmodule

/* tb/sv/tb_linear_blend_vertex_skinning_top.sv */
module tb_linear_blend_vertex_skinning_top;
  import lbvs_pkg::*;

  localparam int InBits = $bits(in_word_t);

  logic clk_i = 0;
  logic rst_ni = 0;
  logic push = 0;
  logic pop = 0;
  logic full, empty;
  in_word_t in_i = '0;
  out_word_t out_o;
  int fail_count, pending;
  bit rx_hold = 0;
  bit calm = 0;
  bit written[DefMaxJoints];

  always #6 clk_i = ~clk_i;

  linear_blend_vertex_skinning_top DUT (
    .clk_i, .rst_ni, .push, .full, .in_i, .empty, .pop, .out_o
  );

  lbvs_checker u_checker (
    .clk_i, .rst_ni, .push_i(push), .full_i(full), .in_i, .empty_i(empty),
    .pop_i(pop), .out_i(out_o), .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    #30_000_000;
    $display("linear_blend_vertex_skinning_top regression: fail");
    $finish;
  end

  // Receiver: random bursts of stalls, one long hold-off on request.
  initial begin
    int n;
    forever begin
      @(negedge clk_i);
      if (rx_hold) begin
        pop <= 0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 7);
        pop <= 0;
        repeat (n - 1) @(negedge clk_i);
      end else begin
        pop <= 1;
      end
    end
  end

  // Returns at the falling edge after the word is taken, with push still high;
  // the caller either sends the next word or drops push at that edge.
  task automatic send(in_word_t w);
    int n;
    if (!calm && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 7);
      push <= 0;
      repeat (n) @(negedge clk_i);
    end
    in_i <= w;
    push <= 1;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic in_word_t noise_word();
    in_word_t w;
    w = InBits'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    return w;
  endfunction

  function automatic logic signed [31:0] pick_val(int mode);
    case ($urandom_range(0, 9))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 32'sd0;
      3, 4: return $urandom;
      default: return $signed($urandom_range(0, 131072)) - 32'sd65536 >>> mode;
    endcase
  endfunction

  task automatic write_joint(int j, bit ident);
    in_word_t w;
    for (int op = 0; op < 2; op++)
      for (int r = 0; r < 4; r++)
        for (int c = 0; c < 4; c++) begin
          w = noise_word();
          w.opcode = (op == 0) ? OpWrCur : OpWrBind;
          w.joint_number = 5'(j);
          w.matrix_row = 2'(r);
          w.matrix_col = 2'(c);
          w.entry_value = ident ? ((r == c) ? 32'sh10000 : 32'sd0) : pick_val(0);
          send(w);
        end
    written[j] = 1;
  endtask

  task automatic contribute(int j, logic signed [31:0] x, logic signed [31:0] y,
                            logic signed [31:0] z, int wt, bit last);
    in_word_t w;
    w = noise_word();
    w.opcode = OpVertex;
    w.joint_number = 5'(j);
    w.pos_x = x; w.pos_y = y; w.pos_z = z;
    w.weight = 17'(wt);
    w.last_of_vertex = last;
    send(w);
  endtask

  function automatic int written_joint();
    int j;
    do j = $urandom_range(0, DefMaxJoints - 1); while (!written[j]);
    return j;
  endfunction

  initial begin
    in_word_t w;
    int cnt, budget;
    repeat (5) @(negedge clk_i);
    rst_ni = 1;
    write_joint(0, 1);
    write_joint(31, 0);
    // Directed: field extremes, no-op, last mark on a write, weight above one.
    contribute(0, 32'sh7fffffff, 32'sh80000000, 32'sd0, 65536, 1);
    contribute(31, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 65536, 0);
    contribute(31, 32'sh80000000, 32'sh80000000, 32'sh80000000, 131071, 1);
    contribute(0, 32'sh10000, 32'sh20000, -32'sh30000, 0, 1);
    w = noise_word(); w.opcode = OpNop; send(w);
    w = noise_word(); w.opcode = OpWrCur; w.joint_number = 0; w.matrix_row = 3;
    w.matrix_col = 3; w.entry_value = 32'sh10000; w.last_of_vertex = 1; send(w);
    contribute(0, 32'sh12345, -32'sh777, 32'sh1, 131071, 0);
    contribute(31, 32'sh7fff0000, 32'sh1, -32'sh1, 32768, 1);
    // Long receiver hold-off so the block backs up and asserts full.
    fork
      begin
        rx_hold = 1;
        repeat (3000) @(negedge clk_i);
        rx_hold = 0;
      end
      begin
        for (int i = 0; i < 12; i++)
          contribute(0, $urandom, $urandom, $urandom, $urandom_range(0, 65536), 1);
        push <= 0;
      end
    join
    for (int j = 1; j < 31; j += 3) write_joint(j, $urandom_range(0, 1));
    cnt = 0;
    budget = 280;
    while (cnt < budget) begin
      if (cnt > budget - 60) calm = 1;
      case ($urandom_range(0, 19))
        0: begin
          w = noise_word();
          w.opcode = OpNop;
          send(w);
        end
        1: begin
          w = noise_word();
          w.opcode = $urandom_range(0, 1) ? OpWrCur : OpWrBind;
          w.joint_number = 5'(written_joint());
          send(w);
          cnt++;
        end
        default: begin
          int parts;
          parts = $urandom_range(1, 4);
          for (int k = 0; k < parts; k++) begin
            contribute(written_joint(), pick_val($urandom_range(0, 12)),
                       pick_val($urandom_range(0, 12)), pick_val($urandom_range(0, 12)),
                       $urandom_range(0, 3) == 0 ? $urandom_range(0, 131071)
                                                 : $urandom_range(0, 65536),
                       k == parts - 1);
            cnt++;
          end
        end
      endcase
    end
    calm = 1;
    push <= 0;
    while (pending != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("linear_blend_vertex_skinning_top regression: pass");
    end else begin
      $display("linear_blend_vertex_skinning_top regression: fail");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/lbvs_pkg.sv
hw/rtl/lbvs_ram.sv
hw/rtl/lbvs_front.sv
hw/rtl/lbvs_back.sv
hw/rtl/linear_blend_vertex_skinning_top.sv
tb/sv/lbvs_checker.sv
tb/sv/tb_linear_blend_vertex_skinning_top.sv
